// ===== hw/rtl/tss_pkg.sv =====
// shared types and constants of the thread slot scheduler
package tss_pkg;

   localparam int FUNC_W       = 2;
   localparam int PRIO_IN_W    = 8;
   localparam int STATUS_W     = 3;
   localparam int SLOT_FIELD_W = 4;
   localparam int ID_W         = 16;
   localparam int POLICY_W     = 2;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [POLICY_W-1:0] policy_type;
   typedef logic [1:0]          slot_state_type;
   typedef logic [ID_W-1:0]     ident_type;

   // request operations
   localparam func_type FUNC_CREATE  = 2'd0;
   localparam func_type FUNC_SCHED   = 2'd1;
   localparam func_type FUNC_YIELD   = 2'd2;
   localparam func_type FUNC_DESTROY = 2'd3;

   // response status codes
   localparam status_type RES_OK     = 3'd0;
   localparam status_type RES_FULL   = 3'd1;
   localparam status_type RES_NONE   = 3'd2;
   localparam status_type RES_NOTRUN = 3'd3;
   localparam status_type RES_IDS    = 3'd4;

   // slot states
   localparam slot_state_type SLOT_FREE  = 2'd0;
   localparam slot_state_type SLOT_RUN   = 2'd1;
   localparam slot_state_type SLOT_YIELD = 2'd2;

   // scheduling policies, the unused code acts as round robin
   localparam policy_type POL_RR   = 2'd0;
   localparam policy_type POL_PRIO = 2'd1;
   localparam policy_type POL_FCFS = 2'd2;

   localparam ident_type ID_MAX = 16'hFFFF;

   // control of the shared compare unit
   typedef struct packed {
      logic       clear;
      logic       valid;
      logic       last_only;
      policy_type policy;
   } pick_ctl_type;

   // write controls of the slot table
   typedef struct packed {
      logic           stat_we;
      logic           mem_we;
      slot_state_type stat_val;
   } store_wr_type;

endpackage

// ===== hw/rtl/tss_req_if.sv =====
// request channel of the thread slot scheduler
interface tss_req_if;
   import tss_pkg::*;

   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [PRIO_IN_W-1:0] new_priority;

   modport source (output valid, func, new_priority, input ready);
   modport sink (input valid, func, new_priority, output ready);
endinterface

// ===== hw/rtl/tss_rsp_if.sv =====
// response channel of the thread slot scheduler
interface tss_rsp_if;
   import tss_pkg::*;

   logic                    valid;
   logic                    ready;
   status_type              status;
   logic [SLOT_FIELD_W-1:0] slot;
   ident_type               tid;

   modport source (output valid, status, slot, tid, input ready);
   modport sink (input valid, status, slot, tid, output ready);
endinterface

// ===== hw/rtl/thread_slot_scheduler.sv =====
// thread slot scheduler top level: sequencer, response register and csr
//
//   channel   | direction | handshake       | payload
//   req_chan  | in        | valid / ready   | func, new_priority
//   rsp_chan  | out       | valid / ready   | status, slot, tid
//   csr       | in        | csr_we          | csr_wdata (scheduling policy)
//
// one request at a time; the slot table is walked one slot per cycle
// create walks from slot 0 up to the first free slot
// schedule walks every slot, through the id/priority memory
// yield and destroy go straight to the response when no thread is running
// reset is synchronous; all slots come up free, no clearing pass needed
// the response sits in an output register, so a stalled rsp_chan only
// holds the next response back, not the next request
module thread_slot_scheduler #(
   parameter int SLOTS     = 16,
   parameter int PRIO_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   tss_req_if.sink             req_chan,
   tss_rsp_if.source           rsp_chan,
   input  logic                csr_we,
   input  tss_pkg::policy_type csr_wdata
);
   import tss_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_FREE_SCAN  = 3'd1;
   localparam logic [2:0] ST_PICK_SCAN  = 3'd2;
   localparam logic [2:0] ST_PICK_DRAIN = 3'd3;
   localparam logic [2:0] ST_PICK_DONE  = 3'd4;
   localparam logic [2:0] ST_REL_ADDR   = 3'd5;
   localparam logic [2:0] ST_REL_DONE   = 3'd6;
   localparam logic [2:0] ST_RESP       = 3'd7;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] last_slot_ff, last_slot_in;
   logic              running_ff, running_in;
   ident_type         id_counter_ff, id_counter_in;
   policy_type        policy_ff, policy_in;
   logic              cand_v_ff, cand_v_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request payload and scan position
   func_type             op_ff, op_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]    steps_ff, steps_in;

   // candidate stage aligned with the memory read
   logic              cand_elig_ff, cand_elig_in;
   logic              cand_last_ff, cand_last_in;
   logic [SLOT_W-1:0] cand_slot_ff, cand_slot_in;

   // pending result and response register
   status_type              res_status_ff, res_status_in;
   logic [SLOT_W-1:0]       res_slot_ff, res_slot_in;
   ident_type               res_id_ff, res_id_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   ident_type               rsp_id_ff, rsp_id_in;

   logic                          req_fire;
   logic                          rsp_load;
   logic                          rd_elig;
   logic [SLOT_W-1:0]             idx_wrap;
   logic [SLOT_W-1:0]             last_wrap;
   ident_type                     id_plus;
   logic [PRIO_BITS+PRIO_IN_W-1:0] prio_ext;
   logic [SLOT_W+SLOT_FIELD_W-1:0] slot_ext;

   slot_state_type       rd_state;
   ident_type            rd_ident;
   logic [PRIO_BITS-1:0] rd_prio;
   store_wr_type         wr;
   logic [SLOT_W-1:0]    wr_addr;
   pick_ctl_type         pick_ctl;
   logic                 have_best;
   logic [SLOT_W-1:0]    best_slot;
   ident_type            best_ident;

   // ---------------------------------------------------------------
   // slot table and shared compare unit
   // ---------------------------------------------------------------
   tss_slot_store #(
      .SLOTS     (SLOTS),
      .PRIO_BITS (PRIO_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (idx_ff),
      .rd_state (rd_state),
      .rd_ident (rd_ident),
      .rd_prio  (rd_prio),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .wr_ident (id_plus),
      .wr_prio  (prio_ff)
   );

   tss_pick_unit #(
      .SLOT_W    (SLOT_W),
      .PRIO_BITS (PRIO_BITS)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .cand_elig  (cand_elig_ff),
      .cand_slot  (cand_slot_ff),
      .cand_prio  (rd_prio),
      .cand_ident (rd_ident),
      .have_best  (have_best),
      .best_slot  (best_slot),
      .best_ident (best_ident)
   );

   // ---------------------------------------------------------------
   // handshakes and small helpers
   // ---------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign rsp_load       = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   assign rd_elig   = (rd_state == SLOT_RUN) || (rd_state == SLOT_YIELD);
   assign idx_wrap  = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign last_wrap = (last_slot_ff == LAST_IDX) ? '0 : last_slot_ff + 1'b1;
   assign id_plus   = id_counter_ff + 1'b1;

   // priority keeps its low PRIO_BITS bits, zero-extended when wider
   assign prio_ext = {{PRIO_BITS{1'b0}}, req_chan.new_priority};
   // response slot field holds the low bits of the slot number
   assign slot_ext = {{SLOT_FIELD_W{1'b0}}, res_slot_ff};

   // compare unit is cleared when a request comes in, fed during the scan
   assign pick_ctl = '{clear:     req_fire,
                       valid:     cand_v_ff,
                       last_only: cand_last_ff,
                       policy:    policy_ff};

   assign policy_in = csr_we ? csr_wdata : policy_ff;

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      last_slot_in  = last_slot_ff;
      running_in    = running_ff;
      id_counter_in = id_counter_ff;
      op_in         = op_ff;
      prio_in       = prio_ff;
      idx_in        = idx_ff;
      steps_in      = steps_ff;
      cand_v_in     = 1'b0;
      cand_elig_in  = rd_elig;
      cand_last_in  = (idx_ff == last_slot_ff);
      cand_slot_in  = idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_id_in     = res_id_ff;
      wr            = '0;
      wr_addr       = idx_ff;

      // response register drains independently of the sequencer
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.func;
               prio_in  = prio_ext[PRIO_BITS-1:0];
               steps_in = '0;
               unique case (req_chan.func)
                  FUNC_CREATE: begin
                     idx_in   = '0;
                     state_in = ST_FREE_SCAN;
                  end
                  FUNC_SCHED: begin
                     // walk starts just after the slot that ran last
                     idx_in   = last_wrap;
                     state_in = ST_PICK_SCAN;
                  end
                  FUNC_YIELD, FUNC_DESTROY: begin
                     if (running_ff) begin
                        idx_in   = last_slot_ff;
                        state_in = ST_REL_ADDR;
                     end else begin
                        res_status_in = RES_NOTRUN;
                        res_slot_in   = '0;
                        res_id_in     = '0;
                        state_in      = ST_RESP;
                     end
                  end
               endcase
            end
         end

         ST_FREE_SCAN: begin
            // lowest free slot wins; full table checked before id exhaustion
            if (rd_state == SLOT_FREE) begin
               if (id_counter_ff == ID_MAX) begin
                  res_status_in = RES_IDS;
                  res_slot_in   = '0;
                  res_id_in     = '0;
               end else begin
                  wr.stat_we    = 1'b1;
                  wr.mem_we     = 1'b1;
                  wr.stat_val   = SLOT_RUN;
                  id_counter_in = id_plus;
                  res_status_in = RES_OK;
                  res_slot_in   = idx_ff;
                  res_id_in     = id_plus;
               end
               state_in = ST_RESP;
            end else if (idx_ff == LAST_IDX) begin
               res_status_in = RES_FULL;
               res_slot_in   = '0;
               res_id_in     = '0;
               state_in      = ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_PICK_SCAN: begin
            // one slot per cycle; the last one visited is last_slot itself
            cand_v_in = 1'b1;
            idx_in    = idx_wrap;
            steps_in  = steps_ff + 1'b1;
            if (steps_ff == LAST_IDX) begin
               state_in = ST_PICK_DRAIN;
            end
         end

         ST_PICK_DRAIN: begin
            // final candidate is being compared
            state_in = ST_PICK_DONE;
         end

         ST_PICK_DONE: begin
            if (have_best) begin
               wr.stat_we    = 1'b1;
               wr.stat_val   = SLOT_RUN;
               wr_addr       = best_slot;
               last_slot_in  = best_slot;
               running_in    = 1'b1;
               res_status_in = RES_OK;
               res_slot_in   = best_slot;
               res_id_in     = best_ident;
            end else begin
               res_status_in = RES_NONE;
               res_slot_in   = '0;
               res_id_in     = '0;
            end
            state_in = ST_RESP;
         end

         ST_REL_ADDR: begin
            // id of the running slot is on its way out of the memory
            state_in = ST_REL_DONE;
         end

         ST_REL_DONE: begin
            wr.stat_we    = 1'b1;
            wr.stat_val   = (op_ff == FUNC_YIELD) ? SLOT_YIELD : SLOT_FREE;
            running_in    = 1'b0;
            res_status_in = RES_OK;
            res_slot_in   = idx_ff;
            res_id_in     = rd_ident;
            state_in      = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_ext[SLOT_FIELD_W-1:0];
               rsp_id_in     = res_id_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_slot_ff  <= LAST_IDX;
         running_ff    <= 1'b0;
         id_counter_ff <= '0;
         policy_ff     <= POL_RR;
         cand_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_slot_ff  <= last_slot_in;
         running_ff    <= running_in;
         id_counter_ff <= id_counter_in;
         policy_ff     <= policy_in;
         cand_v_ff     <= cand_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      prio_ff       <= prio_in;
      idx_ff        <= idx_in;
      steps_ff      <= steps_in;
      cand_elig_ff  <= cand_elig_in;
      cand_last_ff  <= cand_last_in;
      cand_slot_ff  <= cand_slot_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;
   assign rsp_chan.tid    = rsp_id_ff;

`ifndef NO_ASSERTIONS
   // a request always starts work, the sequencer never stays idle
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer idle");

   // ids only move while creating
   a_id_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FREE_SCAN) |=> $stable(id_counter_ff))
      else $error("id counter moved outside create");

   // a successful schedule makes the picked slot the running one
   a_sched_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK_DONE) && have_best
      |=> running_ff && (last_slot_ff == $past(best_slot)))
      else $error("scheduled slot not running");

   // failed requests carry no slot and no id
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != RES_OK)
      |-> (rsp_slot_ff == '0) && (rsp_id_ff == '0))
      else $error("error response with slot or id");
`endif

endmodule

// ===== hw/rtl/tss_slot_store.sv =====
// slot table: state flops plus id and priority memory
module tss_slot_store #(
   parameter int SLOTS     = 16,
   parameter int PRIO_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(SLOTS)-1:0]      rd_addr,
   output tss_pkg::slot_state_type       rd_state,
   output tss_pkg::ident_type            rd_ident,
   output logic [PRIO_BITS-1:0]          rd_prio,
   input  tss_pkg::store_wr_type         wr,
   input  logic [$clog2(SLOTS)-1:0]      wr_addr,
   input  tss_pkg::ident_type            wr_ident,
   input  logic [PRIO_BITS-1:0]          wr_prio
);
   import tss_pkg::*;

   slot_state_type       slot_state_ff [SLOTS];
   slot_state_type       slot_state_in [SLOTS];
   ident_type            ident_ram_ff  [SLOTS];
   logic [PRIO_BITS-1:0] prio_ram_ff   [SLOTS];
   ident_type            rd_ident_ff;
   logic [PRIO_BITS-1:0] rd_prio_ff;

   always_comb begin
      slot_state_in = slot_state_ff;
      if (wr.stat_we) begin
         slot_state_in[wr_addr] = wr.stat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
         end
      end else begin
         slot_state_ff <= slot_state_in;
      end
   end

   // id and priority are read every cycle; they are only used for slots in use
   always_ff @(posedge clock) begin
      if (wr.mem_we) begin
         ident_ram_ff[wr_addr] <= wr_ident;
         prio_ram_ff[wr_addr]  <= wr_prio;
      end
      rd_ident_ff <= ident_ram_ff[rd_addr];
      rd_prio_ff  <= prio_ram_ff[rd_addr];
   end

   assign rd_state = slot_state_ff[rd_addr];
   assign rd_ident = rd_ident_ff;
   assign rd_prio  = rd_prio_ff;

endmodule

// ===== hw/rtl/tss_pick_unit.sv =====
// shared compare unit that keeps the best candidate of a scan
module tss_pick_unit #(
   parameter int SLOT_W    = 4,
   parameter int PRIO_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::pick_ctl_type ctl,
   input  logic                 cand_elig,
   input  logic [SLOT_W-1:0]    cand_slot,
   input  logic [PRIO_BITS-1:0] cand_prio,
   input  tss_pkg::ident_type   cand_ident,
   output logic                 have_best,
   output logic [SLOT_W-1:0]    best_slot,
   output tss_pkg::ident_type   best_ident
);
   import tss_pkg::*;

   logic                 have_ff;
   logic                 have_in;
   logic [SLOT_W-1:0]    best_slot_ff;
   logic [SLOT_W-1:0]    best_slot_in;
   logic [PRIO_BITS-1:0] best_prio_ff;
   logic [PRIO_BITS-1:0] best_prio_in;
   ident_type            best_ident_ff;
   ident_type            best_ident_in;
   logic                 better;
   logic                 take;

   always_comb begin
      unique case (ctl.policy)
         POL_PRIO: better = cand_prio > best_prio_ff;
         POL_FCFS: better = cand_ident < best_ident_ff;
         default:  better = 1'b0;
      endcase
      // the slot that ran last only counts when nothing else qualified
      take = ctl.valid && cand_elig && (!have_ff || (!ctl.last_only && better));

      have_in       = have_ff;
      best_slot_in  = best_slot_ff;
      best_prio_in  = best_prio_ff;
      best_ident_in = best_ident_ff;
      if (ctl.clear) begin
         have_in = 1'b0;
      end else if (take) begin
         have_in       = 1'b1;
         best_slot_in  = cand_slot;
         best_prio_in  = cand_prio;
         best_ident_in = cand_ident;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      best_slot_ff  <= best_slot_in;
      best_prio_ff  <= best_prio_in;
      best_ident_ff <= best_ident_in;
   end

   assign have_best  = have_ff;
   assign best_slot  = best_slot_ff;
   assign best_ident = best_ident_ff;

endmodule
